### rtl/sfx_pkg.sv
// ----------------------------------------------------------------------------
// sfx_pkg
// Shared types and constants of the SPI frame transmitter.
// ----------------------------------------------------------------------------
package sfx_pkg;

    localparam int FRAME_BYTES  = 8;
    localparam int PAYLOAD_DEPTH = FRAME_BYTES - 1;
    localparam int PAYLOAD_AW   = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam int BYTE_POS_W   = $clog2(FRAME_BYTES + 1);

    localparam int HALF_PERIOD_RESET  = 100;
    localparam int CFG_DATA_W         = 16;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_LOAD  = 2'd1,
        OP_START = 2'd2
    } opcode_t;

    typedef enum logic {
        REG_HALF_PERIOD  = 1'b0,
        REG_COMMAND_BYTE = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic chip_select;
        logic data_out;
        logic serial_clock;
        logic busy_res;
        logic accepted;
        logic frame_done;
    } result_t;

endpackage

### rtl/sfx_ram.sv
// ----------------------------------------------------------------------------
// sfx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 7,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/sfx_core.sv
// ----------------------------------------------------------------------------
// sfx_core
// Transfer sequencer: payload store, bit timing and line levels.
// ----------------------------------------------------------------------------
module sfx_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic [1:0]              opcode,
    input  logic [2:0]              byte_index,
    input  logic [7:0]              byte_value,
    input  logic                    last_byte,
    input  logic [15:0]             half_period,
    input  logic [7:0]              command_byte,
    output sfx_pkg::result_t        result
);
    import sfx_pkg::*;

    typedef enum logic [1:0] {
        PH_FALL = 2'd0,
        PH_RISE = 2'd1,
        PH_END  = 2'd2
    } phase_t;

    logic                  pending_reg,  pending_next;
    logic                  active_reg,   active_next;
    logic [15:0]           wait_reg,     wait_next;
    logic [BYTE_POS_W-1:0] byte_pos_reg, byte_pos_next;
    logic [2:0]            bit_pos_reg,  bit_pos_next;
    phase_t                phase_reg,    phase_next;
    logic                  cs_reg,       cs_next;
    logic                  data_reg,     data_next;
    logic                  sclk_reg,     sclk_next;

    logic                  acc_c;
    logic                  done_c;
    logic                  ram_we_c;
    logic [16:0]           wait_inc;
    logic                  elapsed;
    logic [7:0]            ram_rdata;
    logic [7:0]            cur_byte;
    logic [BYTE_POS_W-1:0] rd_pos;
    logic [PAYLOAD_AW-1:0] raddr;
    logic [BYTE_POS_W:0]   byte_pos_inc;

    // read address follows the position the next tick will use
    assign rd_pos = accept ? byte_pos_next : byte_pos_reg;
    assign raddr  = (rd_pos == '0 || int'(rd_pos) >= FRAME_BYTES)
                  ? '0 : PAYLOAD_AW'(rd_pos - BYTE_POS_W'(1));

    sfx_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_DEPTH)
    ) u_payload (
        .clk   (clk),
        .we    (ram_we_c & accept),
        .waddr (PAYLOAD_AW'(byte_index)),
        .wdata (byte_value),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    assign cur_byte     = (byte_pos_reg == '0) ? command_byte : ram_rdata;
    assign wait_inc     = {1'b0, wait_reg} + 17'd1;
    assign elapsed      = (wait_inc >= {1'b0, half_period});
    assign byte_pos_inc = {1'b0, byte_pos_reg} + (BYTE_POS_W + 1)'(1);

    always_comb
    begin
        pending_next  = pending_reg;
        active_next   = active_reg;
        wait_next     = wait_reg;
        byte_pos_next = byte_pos_reg;
        bit_pos_next  = bit_pos_reg;
        phase_next    = phase_reg;
        cs_next       = cs_reg;
        data_next     = data_reg;
        sclk_next     = sclk_reg;
        acc_c         = 1'b0;
        done_c        = 1'b0;
        ram_we_c      = 1'b0;
        case (opcode)
            OP_LOAD:
            begin
                if (!active_reg && int'(byte_index) < PAYLOAD_DEPTH)
                begin
                    ram_we_c = 1'b1;
                    acc_c    = 1'b1;
                    if (last_byte)
                    begin
                        pending_next = 1'b1;
                    end
                end
            end
            OP_START:
            begin
                if (pending_reg && !active_reg)
                begin
                    active_next   = 1'b1;
                    wait_next     = '0;
                    byte_pos_next = '0;
                    bit_pos_next  = 3'd7;
                    phase_next    = PH_FALL;
                    cs_next       = 1'b0;
                    acc_c         = 1'b1;
                end
            end
            OP_TICK:
            begin
                if (active_reg)
                begin
                    if (!elapsed)
                    begin
                        wait_next = wait_inc[15:0];
                    end
                    else
                    begin
                        wait_next = '0;
                        case (phase_reg)
                            PH_FALL:
                            begin
                                sclk_next  = 1'b0;
                                data_next  = cur_byte[bit_pos_reg];
                                phase_next = PH_RISE;
                            end
                            PH_RISE:
                            begin
                                sclk_next  = 1'b1;
                                phase_next = PH_FALL;
                                if (bit_pos_reg == 3'd0)
                                begin
                                    bit_pos_next  = 3'd7;
                                    byte_pos_next = byte_pos_inc[BYTE_POS_W-1:0];
                                    if (int'(byte_pos_inc) >= FRAME_BYTES)
                                    begin
                                        phase_next = PH_END;
                                    end
                                end
                                else
                                begin
                                    bit_pos_next = bit_pos_reg - 3'd1;
                                end
                            end
                            default:
                            begin
                                cs_next       = 1'b1;
                                data_next     = 1'b0;
                                sclk_next     = 1'b0;
                                active_next   = 1'b0;
                                pending_next  = 1'b0;
                                byte_pos_next = '0;
                                bit_pos_next  = 3'd7;
                                phase_next    = PH_FALL;
                                done_c        = 1'b1;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= 1'b0;
            active_reg   <= 1'b0;
            wait_reg     <= '0;
            byte_pos_reg <= '0;
            bit_pos_reg  <= 3'd7;
            phase_reg    <= PH_FALL;
            cs_reg       <= 1'b1;
            data_reg     <= 1'b0;
            sclk_reg     <= 1'b0;
        end
        else if (accept)
        begin
            pending_reg  <= pending_next;
            active_reg   <= active_next;
            wait_reg     <= wait_next;
            byte_pos_reg <= byte_pos_next;
            bit_pos_reg  <= bit_pos_next;
            phase_reg    <= phase_next;
            cs_reg       <= cs_next;
            data_reg     <= data_next;
            sclk_reg     <= sclk_next;
        end
    end

    always_comb
    begin
        result.chip_select  = cs_next;
        result.data_out     = data_next;
        result.serial_clock = sclk_next;
        result.busy_res     = active_next;
        result.accepted     = acc_c;
        result.frame_done   = done_c;
    end

endmodule

### rtl/spi_master_frame_transmitter.sv
// ----------------------------------------------------------------------------
// spi_master_frame_transmitter
// Transmit-only SPI master (mode 0, MSB first) sending a fixed-length frame.
// ----------------------------------------------------------------------------
// Every input transaction (tick, load or start) yields exactly one result
// transaction carrying the line levels after that item. One item is taken per
// clock cycle: the sequencer state updates in the cycle it is accepted and the
// result sits in a single output register, refilled while it drains; a held
// result stalls the input. Payload bytes live in a small synchronous RAM
// whose read address tracks the byte the next tick will shift out, hiding its read latency.
// Loads and starts are refused (accepted = 0) while a frame is in flight.
// ----------------------------------------------------------------------------
module spi_master_frame_transmitter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     opcode,
    input  logic [2:0]                     byte_index,
    input  logic [7:0]                     byte_value,
    input  logic                           last_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           chip_select,
    output logic                           data_out,
    output logic                           serial_clock,
    output logic                           busy_res,
    output logic                           accepted,
    output logic                           frame_done,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [sfx_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sfx_pkg::*;

    logic        accept;
    logic [15:0] half_period_reg;
    logic [7:0]  command_reg;
    logic        out_valid_reg;
    result_t     res_reg;
    result_t     res_c;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    sfx_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .opcode       (opcode),
        .byte_index   (byte_index),
        .byte_value   (byte_value),
        .last_byte    (last_byte),
        .half_period  (half_period_reg),
        .command_byte (command_reg),
        .result       (res_c)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= 16'(HALF_PERIOD_RESET);
            command_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_HALF_PERIOD:  half_period_reg <= cfg_data[15:0];
                REG_COMMAND_BYTE: command_reg     <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_c;
        end
    end

    assign out_valid    = out_valid_reg;
    assign chip_select  = res_reg.chip_select;
    assign data_out     = res_reg.data_out;
    assign serial_clock = res_reg.serial_clock;
    assign busy_res     = res_reg.busy_res;
    assign accepted     = res_reg.accepted;
    assign frame_done   = res_reg.frame_done;

endmodule

### bench/spi_master_frame_transmitter_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI frame transmitter line-level monitor
// Watches the item and result channels and the register port of the SPI
// frame transmitter. It keeps its own model of the shift sequencer, predicts
// the line levels for every item taken in, and compares each result taken
// out against the oldest prediction. It reports the first mismatches and
// hands a failure count and the number of open predictions to the top.
// ----------------------------------------------------------------------------
module spi_master_frame_transmitter_monitor (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [1:0]                     opcode,
    input  logic [2:0]                     byte_index,
    input  logic [7:0]                     byte_value,
    input  logic                           last_byte,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic                           chip_select,
    input  logic                           data_out,
    input  logic                           serial_clock,
    input  logic                           busy_res,
    input  logic                           accepted,
    input  logic                           frame_done,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [sfx_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             outstanding
);
    import sfx_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef enum logic [1:0] {
        WAIT_FALL,
        WAIT_RISE,
        WAIT_RELEASE
    } bit_step_t;

    logic [7:0]  frame_payload [PAYLOAD_DEPTH];
    logic        frame_armed;
    logic        shifting;
    logic [15:0] tick_count;
    int          byte_sel;
    logic [2:0]  bit_sel;
    bit_step_t   step_phase;
    logic        cs_level;
    logic        data_level;
    logic        sclk_level;
    logic [15:0] cfg_half;
    logic [7:0]  cfg_command;

    result_t     levels_q [$];
    result_t     want_levels;
    result_t     seen_levels;
    int          miss_count;

    // true when the current half-period wait has run out
    function automatic logic half_wait_done();
        logic [16:0] next_count;
        next_count = {1'b0, tick_count} + 17'd1;
        if (next_count >= {1'b0, cfg_half})
        begin
            tick_count = '0;
            return 1'b1;
        end
        tick_count = next_count[15:0];
        return 1'b0;
    endfunction

    function automatic logic [7:0] byte_on_wire();
        if (byte_sel == 0)
            return cfg_command;
        return frame_payload[PAYLOAD_AW'(byte_sel - 1)];
    endfunction

    function automatic result_t predict_levels(logic [1:0] op, logic [2:0] idx,
                                               logic [7:0] val, logic last);
        result_t r;
        logic [7:0] cur;
        r = '0;
        case (op)
            OP_LOAD:
            begin
                if (!shifting && idx < PAYLOAD_DEPTH)
                begin
                    frame_payload[idx] = val;
                    if (last)
                        frame_armed = 1'b1;
                    r.accepted = 1'b1;
                end
            end
            OP_START:
            begin
                if (frame_armed && !shifting)
                begin
                    shifting   = 1'b1;
                    tick_count = '0;
                    byte_sel   = 0;
                    bit_sel    = 3'd7;
                    step_phase = WAIT_FALL;
                    cs_level   = 1'b0;
                    r.accepted = 1'b1;
                end
            end
            OP_TICK:
            begin
                if (shifting && half_wait_done())
                begin
                    case (step_phase)
                        WAIT_FALL:
                        begin
                            cur        = byte_on_wire();
                            sclk_level = 1'b0;
                            data_level = cur[bit_sel];
                            step_phase = WAIT_RISE;
                        end
                        WAIT_RISE:
                        begin
                            sclk_level = 1'b1;
                            step_phase = WAIT_FALL;
                            if (bit_sel == 3'd0)
                            begin
                                bit_sel  = 3'd7;
                                byte_sel = byte_sel + 1;
                                if (byte_sel >= FRAME_BYTES)
                                    step_phase = WAIT_RELEASE;
                            end
                            else
                            begin
                                bit_sel = bit_sel - 3'd1;
                            end
                        end
                        default:
                        begin
                            cs_level     = 1'b1;
                            data_level   = 1'b0;
                            sclk_level   = 1'b0;
                            shifting     = 1'b0;
                            frame_armed  = 1'b0;
                            byte_sel     = 0;
                            bit_sel      = 3'd7;
                            step_phase   = WAIT_FALL;
                            r.frame_done = 1'b1;
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase
        r.chip_select  = cs_level;
        r.data_out     = data_level;
        r.serial_clock = sclk_level;
        r.busy_res     = shifting;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (frame_payload[i])
                frame_payload[i] = '0;
            frame_armed = 1'b0;
            shifting    = 1'b0;
            tick_count  = '0;
            byte_sel    = 0;
            bit_sel     = 3'd7;
            step_phase  = WAIT_FALL;
            cs_level    = 1'b1;
            data_level  = 1'b0;
            sclk_level  = 1'b0;
            cfg_half    = 16'(HALF_PERIOD_RESET);
            cfg_command = 8'h00;
            levels_q.delete();
            miss_count  = 0;
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (reg_index_t'(cfg_index))
                    REG_HALF_PERIOD:  cfg_half    = cfg_data[15:0];
                    REG_COMMAND_BYTE: cfg_command = cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && in_ready)
                levels_q.push_back(predict_levels(opcode, byte_index, byte_value, last_byte));
            if (out_valid && out_ready)
            begin
                seen_levels = '{chip_select, data_out, serial_clock, busy_res,
                                accepted, frame_done};
                if (levels_q.size() == 0)
                begin
                    miss_count++;
                    if (miss_count <= MAX_REPORTS)
                        $display("%0t: unexpected result transaction %b", $time, seen_levels);
                end
                else
                begin
                    want_levels = levels_q.pop_front();
                    if (seen_levels !== want_levels)
                    begin
                        miss_count++;
                        if (miss_count <= MAX_REPORTS)
                            $display("%0t: cs/do/sck/busy/acc/done expected %b got %b",
                                     $time, want_levels, seen_levels);
                    end
                end
            end
            fail_count  <= miss_count;
            outstanding <= levels_q.size();
        end
    end

endmodule

### bench/spi_master_frame_transmitter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI frame transmitter testbench
// Drives load, start and tick transactions into the SPI frame transmitter:
// a directed pass over refused loads and starts, overwrites and the zero
// half period, then phases of whole frames with random payloads mixed with
// stray items, under several register settings. Both channels stall at
// random; the monitor predicts and checks every result.
// ----------------------------------------------------------------------------
module spi_master_frame_transmitter_test;

    import sfx_pkg::*;

    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam int         FRAME_WAITS    = FRAME_BYTES * 16 + 1;
    localparam int         SETTLE_CYCLES  = 10;
    localparam int         RX_HOLD_CYCLES = 300;
    localparam int         CYCLE_LIMIT    = 400000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [1:0]            opcode;
    logic [2:0]            byte_index;
    logic [7:0]            byte_value;
    logic                  last_byte;
    logic                  out_valid;
    logic                  out_ready;
    logic                  chip_select;
    logic                  data_out;
    logic                  serial_clock;
    logic                  busy_res;
    logic                  accepted;
    logic                  frame_done;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    outstanding;

    bit                    no_idle = 1'b0;
    bit                    rx_hold = 1'b0;
    bit                    payload_armed = 1'b0;
    int                    useful = 0;
    int                    cycle_count = 0;

    spi_master_frame_transmitter dut (.*);

    spi_master_frame_transmitter_monitor u_monitor (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("[spi_master_frame_transmitter] ERROR");
                $finish;
            end
        end
    end

    // result side: random back-pressure, one long hold on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold)
            begin
                out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge clk);
                rx_hold = 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8) - 1) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send_item(logic [1:0] op, logic [2:0] idx, logic [7:0] val, logic last);
        @(negedge clk);
        if (!no_idle && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        byte_index <= idx;
        byte_value <= val;
        last_byte  <= last;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // load, start or unused opcode that the block must turn down mid-frame
    task automatic send_refused();
        case ($urandom_range(0, 2))
            0: send_item(OP_LOAD, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
            1: send_item(OP_START, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
            default: send_item(OP_UNUSED, 3'($urandom_range(0, 7)),
                               8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        endcase
    endtask

    task automatic run_frame(int ticks, bit pause_mid, bit hold_rx);
        int order [PAYLOAD_DEPTH];
        int j;
        int tmp;
        for (int k = 0; k < PAYLOAD_DEPTH; k++)
            order[k] = k;
        for (int k = PAYLOAD_DEPTH - 1; k > 0; k--)
        begin
            j        = $urandom_range(0, k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        if ($urandom_range(0, 4) == 0)
            send_item(OP_LOAD, 3'd7, 8'($urandom_range(0, 255)), 1'b1);
        for (int k = 0; k < PAYLOAD_DEPTH; k++)
            send_item(OP_LOAD, 3'(order[k]), 8'($urandom_range(0, 255)),
                      k == PAYLOAD_DEPTH - 1);
        if ($urandom_range(0, 3) == 0)
            send_item(OP_LOAD, 3'($urandom_range(0, PAYLOAD_DEPTH - 1)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        send_item(OP_START, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
        if (hold_rx)
            rx_hold = 1'b1;
        for (int k = 0; k < ticks; k++)
        begin
            if (pause_mid && k == ticks / 2)
                wait_drained();
            if ($urandom_range(0, 11) == 0)
                send_refused();
            send_item(OP_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
        end
        payload_armed = 1'b0;
        useful += PAYLOAD_DEPTH + 1 + ticks;
    endtask

    // stray items between frames; a start is only sent while nothing is armed
    task automatic send_noise();
        int n;
        logic [1:0] op;
        logic [2:0] idx;
        logic last;
        n = $urandom_range(1, 6);
        repeat (n)
        begin
            op   = 2'($urandom_range(0, 3));
            idx  = 3'($urandom_range(0, 7));
            last = 1'($urandom_range(0, 1));
            if (op == OP_START && payload_armed)
                op = OP_UNUSED;
            if (op == OP_LOAD && idx < PAYLOAD_DEPTH && last)
                payload_armed = 1'b1;
            if (op == OP_LOAD || op == OP_START)
                useful++;
            send_item(op, idx, 8'($urandom_range(0, 255)), last);
        end
    endtask

    task automatic run_phase(logic [15:0] half, logic [7:0] cmd, bit with_frames,
                             bit stress, int target);
        int stop_at;
        int ticks;
        wait_drained();
        write_reg(REG_HALF_PERIOD, half);
        write_reg(REG_COMMAND_BYTE, cmd);
        ticks   = FRAME_WAITS * ((half == 16'd0) ? 1 : int'(half));
        stop_at = useful + target;
        if (stress)
            run_frame(ticks, 1'b1, 1'b1);
        while (useful < stop_at)
        begin
            if (with_frames && $urandom_range(0, 3) != 0)
                run_frame(ticks, 1'b0, 1'b0);
            else
                send_noise();
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        opcode     = OP_TICK;
        byte_index = '0;
        byte_value = '0;
        last_byte  = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_HALF_PERIOD;
        cfg_data   = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: nothing armed yet
        send_item(OP_START, 3'd0, 8'h00, 1'b0);
        send_item(OP_TICK, 3'd7, 8'hFF, 1'b1);
        send_item(OP_UNUSED, 3'd7, 8'hFF, 1'b1);

        // zero half period, reset command byte
        wait_drained();
        write_reg(REG_HALF_PERIOD, 16'd0);
        send_item(OP_LOAD, 3'd0, 8'h00, 1'b0);
        send_item(OP_LOAD, 3'd1, 8'hFF, 1'b0);
        send_item(OP_LOAD, 3'd2, 8'h80, 1'b0);
        send_item(OP_LOAD, 3'd3, 8'h01, 1'b0);
        send_item(OP_LOAD, 3'd4, 8'h7F, 1'b0);
        send_item(OP_LOAD, 3'd5, 8'hA5, 1'b0);
        send_item(OP_LOAD, 3'd7, 8'hFF, 1'b1);
        send_item(OP_START, 3'd0, 8'h00, 1'b0);
        send_item(OP_LOAD, 3'd6, 8'h5A, 1'b1);
        send_item(OP_LOAD, 3'd0, 8'hC3, 1'b0);
        send_item(OP_START, 3'd0, 8'h00, 1'b0);
        send_item(OP_LOAD, 3'd1, 8'h3C, 1'b1);
        send_item(OP_START, 3'd0, 8'h00, 1'b0);
        send_item(OP_UNUSED, 3'd0, 8'h00, 1'b0);
        repeat (FRAME_WAITS) send_item(OP_TICK, 3'd0, 8'h00, 1'b0);
        send_item(OP_TICK, 3'd0, 8'h00, 1'b0);
        send_item(OP_START, 3'd0, 8'h00, 1'b0);

        run_phase(16'd1, 8'h00, 1'b1, 1'b1, 130);
        run_phase(16'd2, 8'hFF, 1'b1, 1'b0, 250);
        run_phase(16'hFFFF, 8'($urandom_range(0, 255)), 1'b0, 1'b0, 40);
        no_idle = 1'b1;
        run_phase(16'd1, 8'($urandom_range(0, 255)), 1'b1, 1'b0, 130);

        wait_drained();
        if (fail_count == 0)
            $display("[spi_master_frame_transmitter] OK");
        else
            $display("[spi_master_frame_transmitter] ERROR");
        $finish;
    end

endmodule

### filelist.f
rtl/sfx_pkg.sv
rtl/sfx_ram.sv
rtl/sfx_core.sv
rtl/spi_master_frame_transmitter.sv
bench/spi_master_frame_transmitter_monitor.sv
bench/spi_master_frame_transmitter_test.sv
